// ===== hw/rtl/qwbd_pkg.sv =====
// ----------------------------------------------------------------------------
// qwbd_pkg
// Shared types and constants of the quantized weight block dequantizer.
// ----------------------------------------------------------------------------
package qwbd_pkg;

    typedef struct packed {
        logic       sign;
        logic [7:0] exp;
        logic [22:0] frac;
    } t_fp32;

    typedef enum logic [1:0] {
        FMT_TQ2 = 2'd0,
        FMT_Q4K = 2'd1,
        FMT_Q6K = 2'd2,
        FMT_NONE = 2'd3
    } t_fmt;

    localparam int unsigned BUF_BYTES = 210;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

endpackage

// ===== hw/rtl/qwbd_mem.sv =====
// ----------------------------------------------------------------------------
// qwbd_mem
// Block byte buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module qwbd_mem (
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [7:0] i_waddr,
    input  logic [7:0] i_wdata,
    input  logic [7:0] i_raddr,
    output logic [7:0] o_rdata
);

    logic [7:0] mem [qwbd_pkg::BUF_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/qwbd_fmul.sv =====
// ----------------------------------------------------------------------------
// qwbd_fmul
// Single precision value times a small signed integer, rounded to nearest
// even. Operands are zero, normal, infinity or NaN.
// ----------------------------------------------------------------------------
module qwbd_fmul (
    input  qwbd_pkg::t_fp32    i_a,
    input  logic signed [8:0]  i_n,
    output qwbd_pkg::t_fp32    o_p
);

    always_comb begin
        logic        neg;
        logic [8:0]  nabs;
        logic [7:0]  nmag;
        logic [31:0] prod;
        logic [31:0] sh;
        logic [3:0]  s;
        logic [23:0] mant;
        logic        rnd;
        logic [24:0] m25;
        logic [9:0]  e10;
        neg  = i_n[8];
        nabs = neg ? 9'(-i_n) : 9'(i_n);
        nmag = nabs[7:0];
        prod = 32'({1'b1, i_a.frac}) * 32'(nmag);
        s = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (prod[23 + i]) begin
                s = 4'(i);
            end
        end
        sh   = prod << (4'd8 - s);
        mant = sh[31:8];
        rnd  = sh[7] & ((|sh[6:0]) | sh[8]);
        m25  = {1'b0, mant} + 25'(rnd);
        e10  = 10'(i_a.exp) + 10'(s) + 10'(m25[24]);
        o_p.sign = i_a.sign ^ neg;
        o_p.exp  = e10[7:0];
        o_p.frac = m25[24] ? 23'd0 : m25[22:0];
        if (e10 >= 10'(qwbd_pkg::EXP_MAX)) begin
            o_p.exp  = qwbd_pkg::EXP_MAX;
            o_p.frac = 23'd0;
        end
        if (i_a.exp == qwbd_pkg::EXP_MAX) begin
            if (i_a.frac != 23'd0 || nmag == 8'd0) begin
                o_p = qwbd_pkg::CANON_NAN;
            end else begin
                o_p.exp  = qwbd_pkg::EXP_MAX;
                o_p.frac = 23'd0;
            end
        end else if (i_a.exp == 8'd0 || nmag == 8'd0) begin
            o_p.exp  = 8'd0;
            o_p.frac = 23'd0;
        end
    end

endmodule

// ===== hw/rtl/qwbd_fadd.sv =====
// ----------------------------------------------------------------------------
// qwbd_fadd
// Two-stage single precision adder, round to nearest even. Stage one
// aligns, stage two adds, normalizes and rounds.
// ----------------------------------------------------------------------------
module qwbd_fadd (
    input  logic            i_clk,
    input  qwbd_pkg::t_fp32 i_a,
    input  qwbd_pkg::t_fp32 i_b,
    output qwbd_pkg::t_fp32 o_sum
);

    logic            r_sign;
    logic [7:0]      r_exp;
    logic [26:0]     r_ma;
    logic [26:0]     r_mb;
    logic            r_sub;
    logic            r_spec;
    qwbd_pkg::t_fp32 r_spec_val;
    qwbd_pkg::t_fp32 r_sum;

    always_ff @(posedge i_clk) begin
        qwbd_pkg::t_fp32 big;
        qwbd_pkg::t_fp32 sml;
        logic [7:0]  d;
        logic [53:0] ext;
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic        a_zero;
        logic        b_zero;
        logic        spec;
        qwbd_pkg::t_fp32 spec_val;
        a_nan  = (i_a.exp == qwbd_pkg::EXP_MAX) && (i_a.frac != 23'd0);
        b_nan  = (i_b.exp == qwbd_pkg::EXP_MAX) && (i_b.frac != 23'd0);
        a_inf  = (i_a.exp == qwbd_pkg::EXP_MAX) && (i_a.frac == 23'd0);
        b_inf  = (i_b.exp == qwbd_pkg::EXP_MAX) && (i_b.frac == 23'd0);
        a_zero = (i_a.exp == 8'd0);
        b_zero = (i_b.exp == 8'd0);
        if ({i_a.exp, i_a.frac} >= {i_b.exp, i_b.frac}) begin
            big = i_a;
            sml = i_b;
        end else begin
            big = i_b;
            sml = i_a;
        end
        d   = big.exp - sml.exp;
        ext = {1'b1, sml.frac, 3'b000, 27'd0} >> d;
        r_sign <= big.sign;
        r_exp  <= big.exp;
        r_ma   <= {1'b1, big.frac, 3'b000};
        r_sub  <= i_a.sign ^ i_b.sign;
        if (d >= 8'd27) begin
            r_mb <= 27'd1;
        end else begin
            r_mb <= {ext[53:28], ext[27] | (|ext[26:0])};
        end
        spec     = 1'b1;
        spec_val = qwbd_pkg::CANON_NAN;
        if (a_nan || b_nan || (a_inf && b_inf && (i_a.sign != i_b.sign))) begin
            spec_val = qwbd_pkg::CANON_NAN;
        end else if (a_inf) begin
            spec_val = i_a;
        end else if (b_inf) begin
            spec_val = i_b;
        end else if (a_zero && b_zero) begin
            spec_val = {i_a.sign & i_b.sign, 31'd0};
        end else if (a_zero) begin
            spec_val = i_b;
        end else if (b_zero) begin
            spec_val = i_a;
        end else begin
            spec = 1'b0;
        end
        r_spec     <= spec;
        r_spec_val <= spec_val;
    end

    always_ff @(posedge i_clk) begin
        logic [27:0] sum;
        logic [26:0] n;
        logic [4:0]  lead;
        logic [4:0]  lz;
        logic        rnd;
        logic [24:0] m25;
        logic [9:0]  e10;
        qwbd_pkg::t_fp32 res;
        sum = r_sub ? (28'(r_ma) - 28'(r_mb)) : (28'(r_ma) + 28'(r_mb));
        lead = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (sum[i]) begin
                lead = 5'(i);
            end
        end
        lz = 5'd26 - lead;
        if (sum[27]) begin
            n   = {sum[27:2], sum[1] | sum[0]};
            e10 = 10'(r_exp) + 10'd1;
        end else begin
            n   = sum[26:0] << lz;
            e10 = 10'(r_exp) - 10'(lz);
        end
        rnd = n[2] & (n[1] | n[0] | n[3]);
        m25 = {1'b0, n[26:3]} + 25'(rnd);
        e10 = e10 + 10'(m25[24]);
        res.sign = r_sign;
        res.exp  = e10[7:0];
        res.frac = m25[24] ? 23'd0 : m25[22:0];
        if (r_spec) begin
            res = r_spec_val;
        end else if (sum == 28'd0) begin
            res = 32'd0;
        end else if (e10 >= 10'(qwbd_pkg::EXP_MAX)) begin
            res = {r_sign, qwbd_pkg::EXP_MAX, 23'd0};
        end
        r_sum <= res;
    end

    assign o_sum = r_sum;

endmodule

// ===== hw/rtl/quantized_weight_block_dequantizer.sv =====
// ----------------------------------------------------------------------------
// quantized_weight_block_dequantizer
// Byte buffer for one quantized weight block with an fp32 element decoder.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): operation 0 writes i_byte_value to
// buffer position i_byte_index (positions 210 and up are dropped);
// operation 1 decodes element i_element_index by the selected format.
// Output channel (o_valid / i_stall): one fp32 bit pattern per read.
// Config channel (i_cfg_valid / o_cfg_ready): block format, write when idle.
// Writes stream at one per cycle while no read is in progress.
// A read is decoded from eight serial byte reads of the buffer's one
// read port, then the multiply and, for Q4_K, add steps; no new item
// is taken until its result sits in the output register.
// The next item is taken while a result waits in the output register.
// If the receiver stalls with a result held, a second read finishes its
// decode and then waits until the output register frees up.
// Reset clears control state and selects TQ2_0; buffer contents are
// undefined until written.
// ----------------------------------------------------------------------------
module quantized_weight_block_dequantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_element_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_ADD0 = 7'b0001000,
        S_ADD1 = 7'b0010000,
        S_ADD2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state          r_state;
    logic [1:0]      r_fmt;
    logic [7:0]      r_elem;
    logic [3:0]      r_cnt;
    logic [1:0]      r_mstep;
    logic [7:0]      r_byte [8];
    qwbd_pkg::t_fp32 r_x;
    qwbd_pkg::t_fp32 r_y;
    logic            r_ovalid;
    logic [31:0]     r_out;

    logic            in_xfer;
    logic            mem_we;
    logic [7:0]      mem_raddr;
    logic [7:0]      mem_rdata;
    qwbd_pkg::t_fp32 mul_a;
    logic signed [8:0] mul_n;
    qwbd_pkg::t_fp32 mul_p;
    qwbd_pkg::t_fp32 add_sum;
    qwbd_pkg::t_fp32 h_d;
    qwbd_pkg::t_fp32 h_dmin;
    logic [2:0]      j;
    logic [5:0]      q4_sc;
    logic [5:0]      q4_mn;
    logic [3:0]      q4_q;
    logic [1:0]      tq_q;
    logic [3:0]      q6_lo;
    logic [1:0]      q6_hi;
    logic [1:0]      last_step;
    logic            out_free;

    function automatic qwbd_pkg::t_fp32 half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [10:0] sh;
        qwbd_pkg::t_fp32 r;
        ex  = h[14:10];
        man = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                p = 4'(i);
            end
        end
        sh     = 11'(man) << (4'd10 - p);
        r.sign = h[15];
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                r.exp  = 8'd0;
                r.frac = 23'd0;
            end else begin
                r.exp  = 8'd103 + 8'(p);
                r.frac = {sh[9:0], 13'd0};
            end
        end else if (ex == 5'h1F) begin
            r.exp  = qwbd_pkg::EXP_MAX;
            r.frac = {man, 13'd0};
        end else begin
            r.exp  = 8'(ex) + 8'd112;
            r.frac = {man, 13'd0};
        end
        return r;
    endfunction

    assign in_xfer     = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign mem_we      = in_xfer && !i_operation && (i_byte_index < 8'(qwbd_pkg::BUF_BYTES));
    assign out_free    = !r_ovalid || !i_stall;
    assign o_valid      = r_ovalid;
    assign o_value_bits = r_out;

    qwbd_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_byte_index),
        .i_wdata (i_byte_value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        mem_raddr = 8'd0;
        case (r_fmt)
            qwbd_pkg::FMT_TQ2: begin
                case (r_cnt)
                    4'd0:    mem_raddr = 8'({r_elem[7], r_elem[4:0]});
                    4'd1:    mem_raddr = 8'd64;
                    4'd2:    mem_raddr = 8'd65;
                    default: mem_raddr = 8'd0;
                endcase
            end
            qwbd_pkg::FMT_Q4K: begin
                case (r_cnt)
                    4'd0:    mem_raddr = 8'd16 + 8'({r_elem[7:6], r_elem[4:0]});
                    4'd1:    mem_raddr = 8'd0;
                    4'd2:    mem_raddr = 8'd1;
                    4'd3:    mem_raddr = 8'd2;
                    4'd4:    mem_raddr = 8'd3;
                    4'd5:    mem_raddr = 8'd4 + 8'(r_elem[7:5]);
                    4'd6:    mem_raddr = 8'd8 + 8'(r_elem[7:5]);
                    4'd7:    mem_raddr = 8'(r_elem[7:5]);
                    default: mem_raddr = 8'd0;
                endcase
            end
            qwbd_pkg::FMT_Q6K: begin
                case (r_cnt)
                    4'd0:    mem_raddr = 8'({r_elem[7], r_elem[5], r_elem[4:0]});
                    4'd1:    mem_raddr = 8'd128 + 8'({r_elem[7], r_elem[4:0]});
                    4'd2:    mem_raddr = 8'd192 + 8'(r_elem[7:4]);
                    4'd3:    mem_raddr = 8'd208;
                    4'd4:    mem_raddr = 8'd209;
                    default: mem_raddr = 8'd0;
                endcase
            end
            default: mem_raddr = 8'd0;
        endcase
    end

    // operand decode from captured bytes
    always_comb begin
        h_d    = half_to_single((r_fmt == qwbd_pkg::FMT_Q6K) ? {r_byte[4], r_byte[3]}
                                                             : {r_byte[2], r_byte[1]});
        h_dmin = half_to_single({r_byte[4], r_byte[3]});
        j      = r_elem[7:5];
        tq_q   = 2'(r_byte[0] >> {r_elem[6:5], 1'b0});
        q4_q   = r_elem[5] ? r_byte[0][7:4] : r_byte[0][3:0];
        if (!j[2]) begin
            q4_sc = r_byte[5][5:0];
            q4_mn = r_byte[6][5:0];
        end else begin
            q4_sc = {r_byte[7][7:6], r_byte[6][3:0]};
            q4_mn = {r_byte[5][7:6], r_byte[6][7:4]};
        end
        q6_lo = r_elem[6] ? r_byte[0][7:4] : r_byte[0][3:0];
        q6_hi = 2'(r_byte[1] >> {r_elem[6:5], 1'b0});
    end

    always_comb begin
        mul_a     = h_d;
        mul_n     = 9'sd0;
        last_step = 2'd0;
        case (r_fmt)
            qwbd_pkg::FMT_TQ2: begin
                mul_n = $signed(9'(tq_q)) - 9'sd1;
            end
            qwbd_pkg::FMT_Q4K: begin
                last_step = 2'd2;
                case (r_mstep)
                    2'd0: mul_n = $signed(9'(q4_sc));
                    2'd1: begin
                        mul_a = h_dmin;
                        mul_n = $signed(9'(q4_mn));
                    end
                    default: begin
                        mul_a = r_x;
                        mul_n = $signed(9'(q4_q));
                    end
                endcase
            end
            qwbd_pkg::FMT_Q6K: begin
                last_step = 2'd1;
                if (r_mstep == 2'd0) begin
                    mul_n = $signed({r_byte[2][7], r_byte[2]});
                end else begin
                    mul_a = r_x;
                    mul_n = $signed(9'({q6_hi, q6_lo})) - 9'sd32;
                end
            end
            default: mul_n = 9'sd0;
        endcase
    end

    qwbd_fmul u_fmul (
        .i_a (mul_a),
        .i_n (mul_n),
        .o_p (mul_p)
    );

    qwbd_fadd u_fadd (
        .i_clk (i_clk),
        .i_a   (r_x),
        .i_b   ({~r_y.sign, r_y.exp, r_y.frac}),
        .o_sum (add_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fmt    <= qwbd_pkg::FMT_TQ2;
            r_cnt    <= 4'd0;
            r_mstep  <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_fmt <= i_cfg_data;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_operation) begin
                        r_elem  <= i_element_index;
                        r_cnt   <= 4'd0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_cnt != 4'd0) begin
                        r_byte[3'(r_cnt - 4'd1)] <= mem_rdata;
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        r_mstep <= 2'd0;
                        if (r_fmt == qwbd_pkg::FMT_NONE) begin
                            r_x     <= 32'd0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_fmt == qwbd_pkg::FMT_Q4K && r_mstep == 2'd1) begin
                        r_y <= mul_p;
                    end else begin
                        r_x <= mul_p;
                    end
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == last_step) begin
                        r_state <= (r_fmt == qwbd_pkg::FMT_Q4K) ? S_ADD0 : S_OUT;
                    end
                end
                S_ADD0: r_state <= S_ADD1;
                S_ADD1: r_state <= S_ADD2;
                S_ADD2: begin
                    r_x     <= add_sum;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        if (r_x.exp == qwbd_pkg::EXP_MAX && r_x.frac != 23'd0) begin
                            r_out <= qwbd_pkg::CANON_NAN;
                        end else begin
                            r_out <= r_x;
                        end
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_operation) |=> (r_state == S_READ && r_cnt == 4'd0))
        else $error("read transfer did not start buffer reads");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_operation) |=> (r_state == S_IDLE))
        else $error("write transfer left idle");

    a_out_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && i_stall) |=> (r_state == S_OUT && r_ovalid))
        else $error("result dropped while output held");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_cnt <= 4'd8))
        else $error("read counter overrun");

endmodule
